@@ sv/sdps_pkg.sv @@
package sdps_pkg;

	// Default width of the internal timer arithmetic.
	localparam int unsigned TIMER_WIDTH_DEF = 48;

	// Widths of the item fields on the ports.
	localparam int unsigned TIME_W = 48;
	localparam int unsigned POS_W = 32;
	localparam int unsigned IVL_W = 24;
	localparam int unsigned TICK_W = 16;
	localparam int unsigned CFG_ADDR_W = 8;
	localparam int unsigned CFG_DATA_W = 16;

	// An alarm is never scheduled closer than this to the current time.
	localparam int unsigned MIN_MARGIN_US = 5;
	localparam logic [TICK_W-1:0] IDLE_TICK_RESET = 16'd1000;

	// Item kinds.
	localparam logic KIND_ALARM = 1'b0;
	localparam logic KIND_LOAD = 1'b1;

	// Direction codes held between items.
	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_FWD = 2'd1;
	localparam logic [1:0] DIR_BACK = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_ADDR_W-1:0] REG_DOUBLE_EDGE = 8'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_IDLE_TICK = 8'd1;

	typedef struct packed {
		logic kind;
		logic [TIME_W-1:0] timer_now;
		logic signed [POS_W-1:0] target_or_preset;
		logic [IVL_W-1:0] step_interval_us;
	} cmd_t;

	typedef struct packed {
		logic [TIME_W-1:0] alarm_time;
		logic step_taken;
		logic step_line;
		logic dir_line;
		logic signed [POS_W-1:0] position_now;
	} rsp_t;

	typedef struct packed {
		logic [CFG_ADDR_W-1:0] addr;
		logic [CFG_DATA_W-1:0] wdata;
	} cfg_t;

endpackage

@@ sv/sdps_stream_if.sv @@
interface sdps_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ sv/step_dir_pulse_scheduler.sv @@
// Channel  Direction  Payload                                         Role
// cmd      sink       kind, timer_now, target_or_preset,              alarm event or position load
//                     step_interval_us
// rsp      source     alarm_time, step_taken, step_line, dir_line,    one result item per command
//                     position_now
// cfg      sink       addr, wdata                                     register write, always ready
//
// A command item is captured in an input register, evaluated combinationally against the
// held state, and its result lands in the output register.
// One item is accepted every cycle as long as the result side keeps draining. While a
// finished result waits for rsp.ready, the input register can still take one item, after
// which cmd.ready stays low until the waiting result leaves.
// The arst_n reset clears both valid flags, the position, the due time, the direction and
// the step level, and restores the configuration registers to their defaults.
module step_dir_pulse_scheduler #(
	parameter int unsigned TIMER_WIDTH = sdps_pkg::TIMER_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	sdps_stream_if.sink cmd,
	sdps_stream_if.source rsp,
	sdps_stream_if.sink cfg
);
	import sdps_pkg::*;

	localparam int unsigned TW = TIMER_WIDTH;

	// Configuration registers.
	logic double_edge_q;
	logic [TICK_W-1:0] idle_tick_q;

	// Scheduler state carried from item to item.
	logic [POS_W-1:0] pos_q;
	logic [TW-1:0] due_q;
	logic [1:0] dir_q;
	logic step_level_q;

	// Input register and output register.
	logic valid_s1;
	cmd_t cmd_s1;
	logic rsp_valid_q;
	rsp_t rsp_q;

	logic advance;
	logic out_load;

	// Combinational evaluation of the captured item.
	logic [TW-1:0] now_w;
	logic [TW-1:0] ivl_w;
	logic [TW-1:0] base_w;
	logic [TW-1:0] sum_w;
	logic [TW-1:0] due_new_w;
	logic [TW-1:0] idle_alarm_w;
	logic [TW-1:0] min_next_w;
	logic [TW-1:0] raw_w;
	logic [TW-1:0] alarm_w;
	logic is_load;
	logic stand_still;
	logic step_w;
	logic fwd_w;
	logic [POS_W-1:0] pos_next;
	logic [1:0] dir_next;
	logic level_next;
	logic line_w;

	// The result register is free when empty or when its item leaves this cycle.
	assign advance = !rsp_valid_q || rsp.ready;
	assign out_load = valid_s1 && advance;
	assign cmd.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_q;

	always_comb begin
		now_w = TW'(cmd_s1.timer_now);
		ivl_w = TW'(cmd_s1.step_interval_us);
		is_load = (cmd_s1.kind == KIND_LOAD);
		stand_still = (cmd_s1.step_interval_us == '0) ||
			(pos_q == POS_W'(cmd_s1.target_or_preset));
		step_w = !is_load && !stand_still;
		fwd_w = cmd_s1.target_or_preset > $signed(pos_q);

		// Drift-free schedule from the previous due time; restart from now if behind.
		base_w = (due_q != '0) ? due_q : now_w;
		sum_w = base_w + ivl_w;
		due_new_w = (sum_w <= now_w) ? TW'(now_w + ivl_w) : sum_w;

		idle_alarm_w = now_w + TW'(idle_tick_q);
		min_next_w = now_w + TW'(MIN_MARGIN_US);
		raw_w = stand_still ? idle_alarm_w : due_new_w;
		alarm_w = (raw_w < min_next_w) ? min_next_w : raw_w;

		pos_next = pos_q;
		dir_next = dir_q;
		level_next = step_level_q;
		line_w = step_level_q;
		if (is_load) begin
			pos_next = POS_W'(cmd_s1.target_or_preset);
			alarm_w = '0;
		end else if (step_w) begin
			dir_next = fwd_w ? DIR_FWD : DIR_BACK;
			pos_next = fwd_w ? pos_q + 1'b1 : pos_q - 1'b1;
			if (double_edge_q) begin
				level_next = !step_level_q;
				line_w = !step_level_q;
			end else begin
				line_w = 1'b0;
			end
		end
	end

	// Control state and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
			double_edge_q <= 1'b0;
			idle_tick_q <= IDLE_TICK_RESET;
			pos_q <= '0;
			due_q <= '0;
			dir_q <= DIR_NONE;
			step_level_q <= 1'b0;
		end else begin
			if (cmd.ready) begin
				valid_s1 <= cmd.valid;
			end
			if (advance) begin
				rsp_valid_q <= valid_s1;
			end
			if (cfg.valid) begin
				unique case (cfg.data.addr)
					REG_DOUBLE_EDGE: double_edge_q <= cfg.data.wdata[0];
					REG_IDLE_TICK: idle_tick_q <= cfg.data.wdata;
					default: ;
				endcase
			end
			if (out_load) begin
				pos_q <= pos_next;
				dir_q <= dir_next;
				step_level_q <= level_next;
				if (step_w) begin
					due_q <= due_new_w;
				end else if (!is_load) begin
					due_q <= '0;
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			cmd_s1 <= cmd.data;
		end
		if (out_load) begin
			rsp_q.alarm_time <= TIME_W'(alarm_w);
			rsp_q.step_taken <= step_w;
			rsp_q.step_line <= line_w;
			rsp_q.dir_line <= (dir_next == DIR_BACK);
			rsp_q.position_now <= pos_next;
		end
	end

	// A captured item that cannot move on is held unchanged.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(cmd_s1))
		else $error("input register lost or changed a stalled item");

	// An alarm that makes no step leaves no due time behind.
	a_idle_clears_due: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && !is_load && !step_w |=> due_q == '0)
		else $error("due time survived an idle alarm");

	// In pulse mode the step level never moves.
	a_pulse_level: assert property (@(posedge clk) disable iff (!arst_n)
		!double_edge_q |=> $stable(step_level_q))
		else $error("step level changed in pulse mode");

	// A step moves the position, anything else on an alarm keeps it.
	a_pos_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && !is_load |=> (pos_q != $past(pos_q)) == rsp_q.step_taken)
		else $error("position change disagrees with step_taken");

endmodule
